// ----- design/qau_pkg.sv -----
package qau_pkg;

    // Default number of fraction bits (Q16.16).
    localparam int FRAC_BITS_DEF = 16;

    // Width of the exact sums formed before saturation.
    localparam int SUM_W = 66;

    // Quotient and square root bits: one bit is resolved per pipeline stage.
    localparam int QBITS = 33;

    // Register stages inside the quaternion product unit.
    localparam int QM_LAT = 3;

    typedef logic signed [31:0] fx_t;
    typedef fx_t [3:0] quat_t;

    typedef enum logic [2:0] {
        OP_MUL   = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_SCALE = 3'd3,
        OP_DOT   = 3'd4,
        OP_INV   = 3'd5,
        OP_NORM  = 3'd6,
        OP_ROT   = 3'd7
    } op_t;

    typedef struct packed {
        logic clamp;
        fx_t  val;
    } sat_t;

    // Clamp a wide signed value to the 32-bit range and report whether it was clamped.
    function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
        sat_t s;
        if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1)
        begin
            s.clamp = 1'b0;
            s.val   = v[31:0];
        end
        else
        begin
            s.clamp = 1'b1;
            s.val   = v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s;
    endfunction

    // Round a product with 2f fraction bits to f fraction bits, halves rounded up.
    function automatic logic signed [SUM_W-1:0] fround(input logic signed [63:0] p,
                                                       input int f);
        logic signed [63:0] t;
        t = p + (64'sd1 <<< (f - 1));
        return SUM_W'(t >>> f);
    endfunction

endpackage

// ----- design/qau_qmul.sv -----
module qau_qmul
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       en,
    input  quat_t      a,
    input  quat_t      b,
    output quat_t      r,
    output logic [3:0] clamp,
    output fx_t        dot,
    output logic       dot_clamp
);

    localparam int RW = 64 - FRAC_BITS;

    logic signed [63:0]      prod_reg [4][4];
    logic signed [RW-1:0]    term_reg [4][4];
    logic signed [SUM_W-1:0] ext [4][4];
    logic signed [SUM_W-1:0] sum [4];
    logic signed [SUM_W-1:0] dsum;
    sat_t                    sat_r [4];
    sat_t                    sat_d;
    quat_t                   r_reg;
    logic [3:0]              clamp_reg;
    fx_t                     dot_reg;
    logic                    dot_clamp_reg;

    // Stage one forms all sixteen cross products, stage two rounds them.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i][j] <= 64'(a[i]) * 64'(b[j]);
                    term_reg[i][j] <= RW'(fround(prod_reg[i][j], FRAC_BITS));
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ext[i][j] = SUM_W'(term_reg[i][j]);
            end
        end
        sum[0] = ext[1][2] - ext[2][1] + ext[3][0] + ext[0][3];
        sum[1] = ext[2][0] - ext[0][2] + ext[3][1] + ext[1][3];
        sum[2] = ext[0][1] - ext[1][0] + ext[3][2] + ext[2][3];
        sum[3] = ext[3][3] - (ext[0][0] + ext[1][1] + ext[2][2]);
        dsum   = ext[0][0] + ext[1][1] + ext[2][2] + ext[3][3];
        for (int i = 0; i < 4; i++)
        begin
            sat_r[i] = sat32(sum[i]);
        end
        sat_d = sat32(dsum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r_reg[i]     <= sat_r[i].val;
                clamp_reg[i] <= sat_r[i].clamp;
            end
            dot_reg       <= sat_d.val;
            dot_clamp_reg <= sat_d.clamp;
        end
    end

    assign r         = r_reg;
    assign clamp     = clamp_reg;
    assign dot       = dot_reg;
    assign dot_clamp = dot_clamp_reg;

endmodule

// ----- design/quaternion_arithmetic_unit.sv -----
// Quaternion arithmetic unit in signed fixed point with FRAC_BITS fraction bits.
// Input channel: in_valid and in_stall carry one transaction per operation, made of the
// operation code, quaternion a, quaternion or vector b and a scale factor.
// Output channel: out_valid and out_stall carry one transaction per input transaction,
// in order: the result quaternion, the dot value and the degenerate and saturated flags.
// Every operation takes the same path: input register, front stages, the 33-stage
// square root and the 33-stage divider, each resolving one bit per stage, and back end.
// Throughput is one transaction per clock cycle while in_stall is low.
// Reset clears every valid bit in the pipeline and the output register; data registers
// are not reset. When the receiver stalls, the output register holds its result and a
// single skid register catches the next one; once the skid register is full, in_stall
// rises and the whole pipeline holds until the receiver takes the waiting result.
// Results saturate to the 32-bit range. A quaternion of zero norm for inverse, normalise
// or rotate gives zeros with degenerate set.
module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] b_w,
    input  logic signed [31:0] scale_factor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_z,
    output logic signed [31:0] res_w,
    output logic signed [31:0] dot_value,
    output logic        degenerate,
    output logic        saturated
);

    // Rounded squared norm width, divider datapath width and pipeline depth.
    localparam int N2W = 65 - FRAC_BITS;
    localparam int DW  = ((33 + FRAC_BITS) > N2W ? (33 + FRAC_BITS) : N2W) + 2;
    localparam int LAT = 5 + QBITS + 1 + QBITS + 1 + QM_LAT + 1;

    // Everything an item needs from the front end onwards to the divider.
    typedef struct packed {
        op_t            op;
        quat_t          a;
        quat_t          er;
        fx_t            edot;
        logic           eclamp;
        logic [N2W-1:0] n2;
        logic           degen;
    } side_t;

    // What remains after the divider: early results, divider results and flags.
    typedef struct packed {
        op_t   op;
        quat_t er;
        fx_t   edot;
        logic  eclamp;
        logic  degen;
        quat_t dres;
        logic  dclamp;
    } tail_t;

    typedef struct packed {
        quat_t r;
        fx_t   dot;
        logic  degen;
        logic  clamp;
    } res_t;

    logic            en;
    logic [LAT-2:0]  vld_reg;

    // Input register.
    op_t   op0_reg;
    quat_t a0_reg;
    quat_t b0_reg;
    fx_t   sc0_reg;
    quat_t bq;

    // Front product unit.
    quat_t      qm_r;
    logic [3:0] qm_clamp;
    fx_t        qm_dot;
    logic       qm_dclamp;

    // Add, subtract, scale and squared norm alongside the front product unit.
    op_t                op_reg [1:3];
    quat_t              a_reg [1:3];
    quat_t              as_reg [1:3];
    logic [3:0]         as_clamp_reg [1:3];
    logic signed [32:0] asum [4];
    sat_t               as_sat [4];
    logic signed [63:0] scp_reg [4];
    sat_t               sc_sat [4];
    quat_t              sc_reg [2:3];
    logic [3:0]         sc_clamp_reg [2:3];
    logic [62:0]        sq_reg [4];
    logic [63:0]        pair_reg [2];
    logic [64:0]        snorm_reg;
    logic [65:0]        n2_full;
    side_t              side_next;

    // Square root pipeline.
    side_t            side_reg [0:QBITS];
    logic [65:0]      sq_rem_reg [0:QBITS];
    logic [QBITS-1:0] sq_root_reg [0:QBITS];

    // Divider pipeline, four lanes sharing one divisor.
    logic [N2W-1:0]   den;
    logic [31:0]      mag [4];
    logic [DW-1:0]    dv_n_next [4];
    logic [3:0]       dv_neg_next;
    side_t            dv_side_reg [0:QBITS];
    logic [DW-1:0]    dv_n_reg [0:QBITS][4];
    logic [DW-1:0]    dv_d_reg [0:QBITS];
    logic [3:0]       dv_neg_reg [0:QBITS];
    logic [QBITS-1:0] dv_q_reg [0:QBITS][4];
    logic [3:0]       dv_ovf_reg [0:QBITS];

    // Divider finish and rotate back end.
    logic [QBITS:0]          qmag [4];
    logic signed [SUM_W-1:0] qval [4];
    sat_t                    dv_sat [4];
    tail_t                   tail_next;
    tail_t                   tail_reg [0:QM_LAT];
    quat_t                   fq_r;
    logic [3:0]              fq_clamp;

    // Output register and skid register.
    res_t fin;
    logic fin_v;
    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_vld_reg;

    // The pipeline moves whenever the skid register is free.
    assign en       = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg <= op_t'(operation);
            a0_reg  <= {a_w, a_z, a_y, a_x};
            b0_reg  <= {b_w, b_z, b_y, b_x};
            sc0_reg <= scale_factor;
        end
    end

    // Rotation treats b as a pure vector.
    always_comb
    begin
        bq = b0_reg;
        if (op0_reg == OP_ROT)
        begin
            bq[3] = '0;
        end
    end

    // Hamilton product and dot product, three stages.
    qau_qmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .en        (en),
        .a         (a0_reg),
        .b         (bq),
        .r         (qm_r),
        .clamp     (qm_clamp),
        .dot       (qm_dot),
        .dot_clamp (qm_dclamp)
    );

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (op0_reg == OP_SUB)
            begin
                asum[k] = 33'(a0_reg[k]) - 33'(b0_reg[k]);
            end
            else
            begin
                asum[k] = 33'(a0_reg[k]) + 33'(b0_reg[k]);
            end
            as_sat[k] = sat32(SUM_W'(asum[k]));
            sc_sat[k] = sat32(fround(scp_reg[k], FRAC_BITS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage one: add or subtract, scale products and squares.
            op_reg[1] <= op0_reg;
            a_reg[1]  <= a0_reg;
            for (int k = 0; k < 4; k++)
            begin
                as_reg[1][k]       <= as_sat[k].val;
                as_clamp_reg[1][k] <= as_sat[k].clamp;
                scp_reg[k]         <= 64'(a0_reg[k]) * 64'(sc0_reg);
                sq_reg[k]          <= 63'(64'(a0_reg[k]) * 64'(a0_reg[k]));
            end

            // Stage two: round the scale products, add the squares in pairs.
            op_reg[2]       <= op_reg[1];
            a_reg[2]        <= a_reg[1];
            as_reg[2]       <= as_reg[1];
            as_clamp_reg[2] <= as_clamp_reg[1];
            for (int k = 0; k < 4; k++)
            begin
                sc_reg[2][k]       <= sc_sat[k].val;
                sc_clamp_reg[2][k] <= sc_sat[k].clamp;
            end
            pair_reg[0] <= 64'(sq_reg[0]) + 64'(sq_reg[1]);
            pair_reg[1] <= 64'(sq_reg[2]) + 64'(sq_reg[3]);

            // Stage three: the exact squared norm.
            op_reg[3]       <= op_reg[2];
            a_reg[3]        <= a_reg[2];
            as_reg[3]       <= as_reg[2];
            as_clamp_reg[3] <= as_clamp_reg[2];
            sc_reg[3]       <= sc_reg[2];
            sc_clamp_reg[3] <= sc_clamp_reg[2];
            snorm_reg       <= 65'(pair_reg[0]) + 65'(pair_reg[1]);
        end
    end

    // Gather the early results and the rounded squared norm.
    always_comb
    begin
        n2_full          = {1'b0, snorm_reg} + (66'd1 << (FRAC_BITS - 1));
        side_next.op     = op_reg[3];
        side_next.a      = a_reg[3];
        side_next.er     = '0;
        side_next.edot   = '0;
        side_next.eclamp = 1'b0;
        side_next.n2     = n2_full[64:FRAC_BITS];
        side_next.degen  = 1'b0;
        unique case (op_reg[3]) inside
            OP_MUL, OP_ROT:
            begin
                side_next.er     = qm_r;
                side_next.eclamp = |qm_clamp;
            end
            OP_ADD, OP_SUB:
            begin
                side_next.er     = as_reg[3];
                side_next.eclamp = |as_clamp_reg[3];
            end
            OP_SCALE:
            begin
                side_next.er     = sc_reg[3];
                side_next.eclamp = |sc_clamp_reg[3];
            end
            OP_DOT:
            begin
                side_next.edot   = qm_dot;
                side_next.eclamp = qm_dclamp;
            end
            OP_INV, OP_NORM:
            begin
            end
        endcase
        // Normalise fails only on an exactly zero norm; inverse and rotate fail
        // whenever the rounded squared norm is zero.
        if (op_reg[3] == OP_NORM)
        begin
            side_next.degen = (snorm_reg == '0);
        end
        else if (op_reg[3] == OP_INV || op_reg[3] == OP_ROT)
        begin
            side_next.degen = (side_next.n2 == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0]    <= side_next;
            sq_rem_reg[0]  <= {1'b0, snorm_reg};
            sq_root_reg[0] <= '0;
        end
    end

    // Square root, one root bit per stage from the top down. The remainder holds
    // the norm minus the square of the root found so far.
    for (genvar j = 0; j < QBITS; j++)
    begin : g_sqrt
        localparam int I = QBITS - 1 - j;
        logic [67:0] trial;
        logic        take;

        always_comb
        begin
            trial = (68'(sq_root_reg[j]) << (I + 1)) + (68'd1 << (2 * I));
            take  = 68'(sq_rem_reg[j]) >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j+1] <= side_reg[j];
                if (take)
                begin
                    sq_rem_reg[j+1]  <= 66'(68'(sq_rem_reg[j]) - trial);
                    sq_root_reg[j+1] <= sq_root_reg[j] | (QBITS'(1) << I);
                end
                else
                begin
                    sq_rem_reg[j+1]  <= sq_rem_reg[j];
                    sq_root_reg[j+1] <= sq_root_reg[j];
                end
            end
        end
    end

    // Divider set-up. Each lane computes round(|c| * 2^F / den) as
    // floor((2 |c| 2^F + den) / (2 den)), with the sign applied afterwards.
    always_comb
    begin
        if (side_reg[QBITS].op == OP_NORM)
        begin
            den = N2W'(sq_root_reg[QBITS]);
        end
        else
        begin
            den = side_reg[QBITS].n2;
        end
        for (int k = 0; k < 4; k++)
        begin
            mag[k]         = side_reg[QBITS].a[k][31] ? 32'(-side_reg[QBITS].a[k])
                                                      : side_reg[QBITS].a[k];
            dv_n_next[k]   = (DW'(mag[k]) << (FRAC_BITS + 1)) + DW'(den);
            // The inverse negates the vector part.
            dv_neg_next[k] = side_reg[QBITS].a[k][31]
                           ^ ((side_reg[QBITS].op != OP_NORM) && (k < 3));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= side_reg[QBITS];
            dv_d_reg[0]    <= DW'(den) << 1;
            dv_neg_reg[0]  <= dv_neg_next;
            dv_ovf_reg[0]  <= '0;
            for (int k = 0; k < 4; k++)
            begin
                dv_n_reg[0][k] <= dv_n_next[k];
                dv_q_reg[0][k] <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage in all four lanes. The first
    // stage also flags quotients too large for the quotient register.
    for (genvar j = 0; j < QBITS; j++)
    begin : g_div
        localparam int I = QBITS - 1 - j;
        logic [3:0] qbit;
        logic [3:0] ovf_next;

        always_comb
        begin
            for (int k = 0; k < 4; k++)
            begin
                qbit[k] = (dv_n_reg[j][k] >> I) >= dv_d_reg[j];
                if (j == 0)
                begin
                    ovf_next[k] = (dv_n_reg[j][k] >> QBITS) >= dv_d_reg[j];
                end
                else
                begin
                    ovf_next[k] = dv_ovf_reg[j][k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[j+1] <= dv_side_reg[j];
                dv_d_reg[j+1]    <= dv_d_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_ovf_reg[j+1]  <= ovf_next;
                for (int k = 0; k < 4; k++)
                begin
                    if (qbit[k])
                    begin
                        dv_n_reg[j+1][k] <= dv_n_reg[j][k] - (dv_d_reg[j] << I);
                    end
                    else
                    begin
                        dv_n_reg[j+1][k] <= dv_n_reg[j][k];
                    end
                    dv_q_reg[j+1][k] <= {dv_q_reg[j][k][QBITS-2:0], qbit[k]};
                end
            end
        end
    end

    // Apply the signs, saturate and hand on to the rotate back end.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (dv_ovf_reg[QBITS][k])
            begin
                qmag[k] = (QBITS + 1)'(1) << QBITS;
            end
            else
            begin
                qmag[k] = {1'b0, dv_q_reg[QBITS][k]};
            end
            qval[k] = SUM_W'(qmag[k]);
            if (dv_neg_reg[QBITS][k])
            begin
                qval[k] = -qval[k];
            end
            dv_sat[k]         = sat32(qval[k]);
            tail_next.dres[k] = dv_sat[k].val;
        end
        tail_next.op     = dv_side_reg[QBITS].op;
        tail_next.er     = dv_side_reg[QBITS].er;
        tail_next.edot   = dv_side_reg[QBITS].edot;
        tail_next.eclamp = dv_side_reg[QBITS].eclamp;
        tail_next.degen  = dv_side_reg[QBITS].degen;
        tail_next.dclamp = dv_sat[0].clamp | dv_sat[1].clamp
                         | dv_sat[2].clamp | dv_sat[3].clamp;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tail_reg[0] <= tail_next;
            for (int i = 0; i < QM_LAT; i++)
            begin
                tail_reg[i+1] <= tail_reg[i];
            end
        end
    end

    // Second half of the rotation: (a * v) * inverse(a).
    qau_qmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .en        (en),
        .a         (tail_reg[0].er),
        .b         (tail_reg[0].dres),
        .r         (fq_r),
        .clamp     (fq_clamp),
        .dot       (),
        .dot_clamp ()
    );

    // Final selection. A degenerate item returns zeros and no saturation.
    always_comb
    begin
        fin_v     = vld_reg[LAT-2];
        fin.r     = '0;
        fin.dot   = '0;
        fin.degen = tail_reg[QM_LAT].degen;
        fin.clamp = 1'b0;
        if (!tail_reg[QM_LAT].degen)
        begin
            unique case (tail_reg[QM_LAT].op) inside
                OP_MUL, OP_ADD, OP_SUB, OP_SCALE, OP_DOT:
                begin
                    fin.r     = tail_reg[QM_LAT].er;
                    fin.dot   = tail_reg[QM_LAT].edot;
                    fin.clamp = tail_reg[QM_LAT].eclamp;
                end
                OP_INV, OP_NORM:
                begin
                    fin.r     = tail_reg[QM_LAT].dres;
                    fin.clamp = tail_reg[QM_LAT].dclamp;
                end
                OP_ROT:
                begin
                    fin.r     = fq_r;
                    fin.r[3]  = '0;
                    fin.clamp = tail_reg[QM_LAT].eclamp | tail_reg[QM_LAT].dclamp
                              | (|fq_clamp);
                end
            endcase
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_vld_reg  <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_vld_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_vld_reg  <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fin_v;
            end
        end
        else if (fin_v && en)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_reg <= skid_vld_reg ? skid_reg : fin;
        end
        else if (fin_v && en)
        begin
            skid_reg <= fin;
        end
    end

    assign out_valid  = out_valid_reg;
    assign res_x      = out_reg.r[0];
    assign res_y      = out_reg.r[1];
    assign res_z      = out_reg.r[2];
    assign res_w      = out_reg.r[3];
    assign dot_value  = out_reg.dot;
    assign degenerate = out_reg.degen;
    assign saturated  = out_reg.clamp;

endmodule
